/* hw/rtl/ptw_pkg.sv */
// Package for the Sv39 page table walker: payload structs, status and
// register codes, and default sizes. No dependencies.
package ptw_pkg;

	localparam int TABLE_PAGES_DEF  = 16;
	localparam int ENTRIES_PER_PAGE = 512;
	localparam int IDX_W            = 9;
	localparam int PPN_W            = 44;
	localparam int PA_W             = 56;
	localparam int VA_W             = 64;
	localparam int VA_LIMIT_BIT     = 38;
	localparam int PTE_W            = 64;
	localparam int SLOT_W           = 13;
	localparam int STATUS_W         = 3;

	localparam logic OP_WRITE     = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	localparam logic CFG_ROOT_PPN  = 1'b0;
	localparam logic CFG_STORE_PPN = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_VA_HIGH      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_L2_INVALID   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_L1_INVALID   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LEAF_INVALID = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_USER     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE      = 3'd6;

	localparam int PTE_BIT_VALID = 0;
	localparam int PTE_BIT_USER  = 4;
	localparam int PTE_PPN_LSB   = 10;

	typedef struct packed {
		logic              opcode;
		logic [VA_W-1:0]   virt_addr;
		logic [SLOT_W-1:0] store_index;
		logic [PTE_W-1:0]  pte_word;
	} ptw_req_t;

	typedef struct packed {
		logic [PA_W-1:0]     phys_page_addr;
		logic [STATUS_W-1:0] status;
	} ptw_rsp_t;

	typedef struct packed {
		logic             index;
		logic [PTE_W-1:0] data;
	} ptw_cfg_t;

endpackage

/* hw/rtl/ptw_chan_if.sv */
// Valid/ready channel carrying one payload word of a given type.
// Used with the payload structs of ptw_pkg.
interface ptw_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hw/rtl/sv39_page_table_walker.sv */
// Sv39 page table walker over an internal PTE store.
// Depends on ptw_pkg, ptw_chan_if and ptw_ram.
//
// Channel  Dir  Payload                                   Word moves when
// req      in   opcode, virt_addr, store_index, pte_word  req.valid & req.ready
// rsp      out  phys_page_addr, status                    rsp.valid & rsp.ready
// cfg      in   index, data                               cfg.valid & cfg.ready
//
// From one accepted word to the next: a store write or a too-high address goes straight to the
// result; a translation runs a range check and a store read for each level reached, up to a
// full three-level walk, and stops at an invalid entry or after the range check when the table
// page reached lies outside the store. A new word is taken only once the last is finished. After
// reset the store is cleared one entry a cycle, and req.ready stays low meanwhile. Configuration
// words are always taken. A stalled rsp holds the finished result while the next word is taken.
module sv39_page_table_walker #(
	parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ptw_chan_if.sink   req,
	ptw_chan_if.source rsp,
	ptw_chan_if.sink   cfg
);
	import ptw_pkg::*;

	localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW - IDX_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RANGE = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [1:0]          level_q;
	logic [PPN_W-1:0]    ppn_q;
	logic [VA_W-1:0]     va_q;
	logic [PPN_W-1:0]    root_ppn_q;
	logic [PPN_W-1:0]    base_ppn_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [PA_W-1:0]     res_addr_q;
	logic                rsp_valid_q;
	ptw_rsp_t            rsp_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [PTE_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [PTE_W-1:0]    pte;
	logic [PPN_W:0]      diff;
	logic                outside;
	logic [IDX_W-1:0]    idx;
	logic [AW+SLOT_W-1:0] slot_ext;
	logic                slot_ok;
	logic                req_fire;
	logic                rsp_load;

	ptw_ram #(
		.WIDTH(PTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(pte)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign slot_ext = {{AW{1'b0}}, req.data.store_index};
	assign slot_ok  = (slot_ext < (AW+SLOT_W)'(DEPTH));

	// The range check is the one wide subtract and compare reused at every level.
	assign diff    = {1'b0, ppn_q} - {1'b0, base_ppn_q};
	assign outside = diff[PPN_W] || (diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));

	always_comb begin
		case (level_q)
			2'd2:    idx = va_q[38:30];
			2'd1:    idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = req_fire && (req.data.opcode == OP_WRITE) && slot_ok;
			ram_waddr = slot_ext[AW-1:0];
			ram_wdata = req.data.pte_word;
		end
	end

	assign ram_re    = (state_q == S_RANGE) && !outside;
	assign ram_raddr = {diff[PW-1:0], idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_ppn_q <= '0;
			base_ppn_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.data.index == CFG_ROOT_PPN) begin
				root_ppn_q <= cfg.data.data[PPN_W-1:0];
			end else begin
				base_ppn_q <= cfg.data.data[PPN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			level_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						level_q <= 2'd2;
						if (req.data.opcode == OP_WRITE ||
							req.data.virt_addr[VA_W-1:VA_LIMIT_BIT] != '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RANGE;
						end
					end
				end
				S_RANGE: begin
					state_q <= outside ? S_DONE : S_READ;
				end
				S_READ: begin
					if (pte[PTE_BIT_VALID] && level_q != 2'd0) begin
						level_q <= level_q - 1'b1;
						state_q <= S_RANGE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				va_q       <= req.data.virt_addr;
				ppn_q      <= root_ppn_q;
				res_addr_q <= '0;
				if (req.data.opcode == OP_TRANSLATE &&
					req.data.virt_addr[VA_W-1:VA_LIMIT_BIT] != '0) begin
					res_status_q <= ST_VA_HIGH;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_RANGE: begin
				if (outside) begin
					res_status_q <= ST_OUTSIDE;
				end
			end
			S_READ: begin
				ppn_q <= pte[PTE_PPN_LSB +: PPN_W];
				if (!pte[PTE_BIT_VALID]) begin
					case (level_q)
						2'd2:    res_status_q <= ST_L2_INVALID;
						2'd1:    res_status_q <= ST_L1_INVALID;
						default: res_status_q <= ST_LEAF_INVALID;
					endcase
				end else if (level_q == 2'd0) begin
					if (!pte[PTE_BIT_USER]) begin
						res_status_q <= ST_NOT_USER;
					end else begin
						res_addr_q <= {pte[PTE_PPN_LSB +: PPN_W], 12'h000};
					end
				end
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.phys_page_addr <= res_addr_q;
			rsp_q.status         <= res_status_q;
		end
	end

`ifndef SYNTH
	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status != ST_OK |-> rsp.data.phys_page_addr == '0)
		else $error("failed translation carries a nonzero address");

	a_read_after_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> $past(state_q) == S_RANGE)
		else $error("store data checked without a preceding read");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_CLEAR))
		else $error("store written during a walk");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second word taken while one is in progress");
`endif
endmodule
